// ===== sv/bmcb_pkg.sv =====
// shared types, constants and helpers for the battery mode and cell balance block
package bmcb_pkg;

  localparam int TIME_BITS     = 48;
  localparam int ADC_BITS      = 14;
  localparam int CUR_BITS      = 16;
  localparam int DB_BITS       = 15;
  localparam int TMR_BITS      = 32;
  localparam int POS_BITS      = 3;
  localparam int MASK_BITS     = 5;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_ADDR_BITS-1:0] CFG_DEADBAND  = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IDLE_SHUT = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_BAL_PER   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_BAL_ON    = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IMB_MIN   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IMB_MAX   = 3'd5;

  localparam logic [DB_BITS-1:0]  RST_DEADBAND  = 15'd10;
  localparam logic [TMR_BITS-1:0] RST_IDLE_SHUT = 32'd10000000;
  localparam logic [TMR_BITS-1:0] RST_BAL_PER   = 32'd6000000;
  localparam logic [TMR_BITS-1:0] RST_BAL_ON    = 32'd5000000;
  localparam logic [ADC_BITS-1:0] RST_IMB_MIN   = ADC_BITS'(25);
  localparam logic [ADC_BITS-1:0] RST_IMB_MAX   = ADC_BITS'(1000);

  localparam logic [POS_BITS-1:0] POS_A = 3'd0;
  localparam logic [POS_BITS-1:0] POS_B = 3'd1;
  localparam logic [POS_BITS-1:0] POS_C = 3'd4;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_CHG     = 3'd1,
    MODE_DSG     = 3'd2,
    MODE_IDLEBAL = 3'd3,
    MODE_IDLE    = 3'd4
  } mode_t;

  typedef struct packed {
    logic [DB_BITS-1:0]  current_deadband;
    logic [TMR_BITS-1:0] idle_shutdown_us;
    logic [TMR_BITS-1:0] balance_period_us;
    logic [TMR_BITS-1:0] balance_on_us;
    logic [ADC_BITS-1:0] imbalance_min;
    logic [ADC_BITS-1:0] imbalance_max;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]       now_us;
    logic signed [CUR_BITS-1:0] current_code;
    logic [ADC_BITS-1:0]        cell_a;
    logic [ADC_BITS-1:0]        cell_b;
    logic [ADC_BITS-1:0]        cell_c;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           battery_mode;
    logic                 bleed_write;
    logic [MASK_BITS-1:0] bleed_mask;
    logic                 bleed_active;
    logic [POS_BITS-1:0]  bleed_cell;
    logic                 shutdown_request;
    logic [ADC_BITS-1:0]  spread;
  } out_item_t;

  function automatic logic [POS_BITS-1:0] cell_pos(input logic [1:0] idx);
    logic [POS_BITS-1:0] p;
    case (idx)
      2'd1:    p = POS_B;
      2'd2:    p = POS_C;
      default: p = POS_A;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/battery_mode_and_cell_balance.sv =====
// top level: input register, tick logic, result register and handshake
// an accepted beat is held in the input register, then in the result register that drives out_data
// throughput: one beat per cycle while out_stall is low; the tick logic sits between the input and result registers
// state advances as each beat moves from the input register to the result register
// reset (synchronous, rst_n low): both registers empty, mode initializing, timers zero
// configuration returns to its default values on reset
module battery_mode_and_cell_balance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bmcb_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bmcb_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bmcb_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [bmcb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  bmcb_pkg::cfg_t      cfg;
  bmcb_pkg::in_item_t  in_data_r;
  bmcb_pkg::out_item_t out_data_r, res;
  logic                in_valid_r, out_valid_r;
  logic                out_load, adv, in_take;

  assign out_load = !out_valid_r || !out_stall;
  assign adv      = in_valid_r && out_load;
  assign in_stall = in_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  bmcb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bmcb_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (adv),
    .item    (in_data_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input beat moves on whenever the result register is free
  a_adv_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_valid_r |=> out_valid_r)
    else $error("held beat did not move to result register");

  a_cell_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.bleed_active || out_data_r.bleed_cell == '0))
    else $error("bleed cell set while not bleeding");

  a_mask_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($onehot0(out_data_r.bleed_mask) &&
                     (out_data_r.bleed_mask == '0 || out_data_r.bleed_write)))
    else $error("bad bleed mask");

  a_shut_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.shutdown_request |->
      out_data_r.battery_mode == bmcb_pkg::MODE_IDLE)
    else $error("shutdown outside idle mode");

endmodule

// ===== sv/bmcb_cfg.sv =====
// configuration register file with plain write port
module bmcb_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bmcb_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [bmcb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output bmcb_pkg::cfg_t                      cfg
);

  bmcb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_deadband  <= bmcb_pkg::RST_DEADBAND;
      cfg_r.idle_shutdown_us  <= bmcb_pkg::RST_IDLE_SHUT;
      cfg_r.balance_period_us <= bmcb_pkg::RST_BAL_PER;
      cfg_r.balance_on_us     <= bmcb_pkg::RST_BAL_ON;
      cfg_r.imbalance_min     <= bmcb_pkg::RST_IMB_MIN;
      cfg_r.imbalance_max     <= bmcb_pkg::RST_IMB_MAX;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bmcb_pkg::CFG_DEADBAND:
          cfg_r.current_deadband <= cfg_wdata[bmcb_pkg::DB_BITS-1:0];
        bmcb_pkg::CFG_IDLE_SHUT:
          cfg_r.idle_shutdown_us <= cfg_wdata[bmcb_pkg::TMR_BITS-1:0];
        bmcb_pkg::CFG_BAL_PER:
          cfg_r.balance_period_us <= cfg_wdata[bmcb_pkg::TMR_BITS-1:0];
        bmcb_pkg::CFG_BAL_ON:
          cfg_r.balance_on_us <= cfg_wdata[bmcb_pkg::TMR_BITS-1:0];
        bmcb_pkg::CFG_IMB_MIN:
          cfg_r.imbalance_min <= cfg_wdata[bmcb_pkg::ADC_BITS-1:0];
        bmcb_pkg::CFG_IMB_MAX:
          cfg_r.imbalance_max <= cfg_wdata[bmcb_pkg::ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/bmcb_step.sv =====
// per-tick mode, timer and balance logic with its state registers
module bmcb_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick_en,
  input  bmcb_pkg::in_item_t   item,
  input  bmcb_pkg::cfg_t       cfg,
  output bmcb_pkg::out_item_t  res
);

  localparam int TB = bmcb_pkg::TIME_BITS;
  localparam int AB = bmcb_pkg::ADC_BITS;

  bmcb_pkg::mode_t                mode_r, mode_nxt;
  logic [TB-1:0]                  acc_r, acc_nxt;
  logic [TB-1:0]                  prev_r;
  logic [TB-1:0]                  idle_since_r, idle_since_nxt;
  logic [TB-1:0]                  bal_start_r, bal_start_nxt;
  logic [bmcb_pkg::POS_BITS-1:0]  bleed_cell_r, bleed_cell_nxt;
  logic                           bleed_on_r, bleed_on_nxt;

  logic [TB-1:0]                  now;
  logic [TB-1:0]                  dt;
  logic [TB:0]                    acc_sum;
  logic signed [bmcb_pkg::CUR_BITS:0] cur_x, db_x;
  logic                           is_chg, is_dsg;
  logic [TB-1:0]                  idle_el, bal_el;
  logic                           shut;
  logic [AB-1:0]                  cv0, cv1, cv2, v_hi, v_lo, hi01, lo01;
  logic [1:0]                     hi_idx;
  logic [AB-1:0]                  spread;
  logic                           wr;
  logic [bmcb_pkg::MASK_BITS-1:0] mask;
  logic [bmcb_pkg::POS_BITS-1:0]  hi_pos;

  always_comb begin
    now     = item.now_us;
    dt      = (now >= prev_r) ? now - prev_r : '0;
    acc_sum = {1'b0, acc_r} + {1'b0, dt};
    cur_x   = {item.current_code[bmcb_pkg::CUR_BITS-1], item.current_code};
    db_x    = $signed({2'b00, cfg.current_deadband});
    is_chg  = cur_x > db_x;
    is_dsg  = cur_x < -db_x;

    mode_nxt       = mode_r;
    acc_nxt        = acc_r;
    idle_since_nxt = idle_since_r;
    shut           = 1'b0;
    idle_el        = '0;

    if (is_chg) begin
      mode_nxt = bmcb_pkg::MODE_CHG;
      acc_nxt  = acc_sum[TB] ? '1 : acc_sum[TB-1:0];
    end else if (is_dsg) begin
      mode_nxt = bmcb_pkg::MODE_DSG;
      acc_nxt  = '0;
    end else begin
      if (mode_r != bmcb_pkg::MODE_IDLE) idle_since_nxt = now;
      mode_nxt = (acc_r != '0) ? bmcb_pkg::MODE_IDLEBAL : bmcb_pkg::MODE_IDLE;
      acc_nxt  = (acc_r > dt) ? acc_r - dt : '0;
      idle_el  = (now >= idle_since_nxt) ? now - idle_since_nxt : '0;
      shut     = (mode_nxt == bmcb_pkg::MODE_IDLE) &&
                 (idle_el > TB'(cfg.idle_shutdown_us));
    end

    // highest and lowest cell, ties to the lower position
    cv0    = item.cell_a;
    cv1    = item.cell_b;
    cv2    = item.cell_c;
    hi_idx = (cv1 > cv0) ? 2'd1 : 2'd0;
    hi01   = (cv1 > cv0) ? cv1 : cv0;
    lo01   = (cv1 < cv0) ? cv1 : cv0;
    if (cv2 > hi01) hi_idx = 2'd2;
    v_hi   = (cv2 > hi01) ? cv2 : hi01;
    v_lo   = (cv2 < lo01) ? cv2 : lo01;
    spread = v_hi - v_lo;
    hi_pos = bmcb_pkg::cell_pos(hi_idx);

    bal_start_nxt  = bal_start_r;
    bleed_cell_nxt = bleed_cell_r;
    bleed_on_nxt   = bleed_on_r;
    wr             = 1'b0;
    mask           = '0;
    bal_el         = (now >= bal_start_r) ? now - bal_start_r : '0;

    if (mode_nxt == bmcb_pkg::MODE_CHG || mode_nxt == bmcb_pkg::MODE_IDLEBAL) begin
      if (spread > cfg.imbalance_min && spread < cfg.imbalance_max) begin
        if (bal_el > TB'(cfg.balance_period_us)) begin
          bal_start_nxt  = now;
          wr             = 1'b1;
          mask           = bmcb_pkg::MASK_BITS'(1) << hi_pos;
          bleed_cell_nxt = hi_pos;
          bleed_on_nxt   = 1'b1;
        end else if (bal_el > TB'(cfg.balance_on_us)) begin
          wr             = 1'b1;
          bleed_on_nxt   = 1'b0;
          bleed_cell_nxt = '0;
        end
      end else begin
        if (mode_nxt == bmcb_pkg::MODE_IDLEBAL) acc_nxt = '0;
        wr             = 1'b1;
        bleed_on_nxt   = 1'b0;
        bleed_cell_nxt = '0;
      end
    end else begin
      wr             = 1'b1;
      bleed_on_nxt   = 1'b0;
      bleed_cell_nxt = '0;
    end

    res.battery_mode     = mode_nxt;
    res.bleed_write      = wr;
    res.bleed_mask       = mask;
    res.bleed_active     = bleed_on_nxt;
    res.bleed_cell       = bleed_on_nxt ? bleed_cell_nxt : '0;
    res.shutdown_request = shut;
    res.spread           = spread;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= bmcb_pkg::MODE_INIT;
      acc_r        <= '0;
      prev_r       <= '0;
      idle_since_r <= '0;
      bal_start_r  <= '0;
      bleed_cell_r <= '0;
      bleed_on_r   <= 1'b0;
    end else if (tick_en) begin
      mode_r       <= mode_nxt;
      acc_r        <= acc_nxt;
      prev_r       <= now;
      idle_since_r <= idle_since_nxt;
      bal_start_r  <= bal_start_nxt;
      bleed_cell_r <= bleed_cell_nxt;
      bleed_on_r   <= bleed_on_nxt;
    end
  end

endmodule
